// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker module of the block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define ISFC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("isfc assertion failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define ISFC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("isfc assertion failed");

`endif

// ===== rtl/isfc_pkg.sv =====
// Types and constants shared by the I2C slave FIFO controller modules.
package isfc_pkg;

  typedef enum logic [3:0] {
    FUNC_HOST_READ  = 4'd0,
    FUNC_HOST_WRITE = 4'd1,
    FUNC_ADDR_WRITE = 4'd2,
    FUNC_RX_ACK     = 4'd3,
    FUNC_RX_NACK    = 4'd4,
    FUNC_STOP       = 4'd5,
    FUNC_TX_REQ     = 4'd6,
    FUNC_TX_NACK    = 4'd7,
    FUNC_FAULT      = 4'd8
  } func_e;

  typedef enum logic [3:0] {
    OP_IGNORE,
    OP_HOST_READ,
    OP_HOST_WRITE,
    OP_ADDR_WRITE,
    OP_RX_ACK,
    OP_RX_NACK,
    OP_RELEASE,
    OP_TX_REQ,
    OP_FAULT
  } op_e;

  typedef enum logic [1:0] {
    CTL_NONE = 2'd0,
    CTL_ACK  = 2'd1,
    CTL_NACK = 2'd2,
    CTL_OFF  = 2'd3
  } ctl_e;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_FULL  = 2'd1,
    ERR_FAULT = 2'd2,
    ERR_BUSY  = 2'd3
  } err_e;

  localparam logic [7:0] BYTE_NONE = 8'hFF;
  localparam logic [3:0] COUNT_MAX = 4'hF;

  typedef struct packed {
    op_e        op;
    logic [7:0] data;
  } cmd_t;

endpackage

// ===== rtl/isfc_ifs.sv =====
// Request and result channel interfaces of the I2C slave FIFO controller.
interface isfc_req_if;
  logic       valid;
  logic       ready;
  logic [3:0] func;
  logic [7:0] data_in;

  modport source (output valid, output func, output data_in, input ready);
  modport sink (input valid, input func, input data_in, output ready);
endinterface

interface isfc_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_out;
  logic [1:0] bus_control;
  logic       read_empty;
  logic       frame_last;
  logic       write_accepted;
  logic [1:0] error_code;
  logic [3:0] receive_count;
  logic [3:0] transmit_pending;

  modport source (
    output valid, output data_out, output bus_control, output read_empty,
    output frame_last, output write_accepted, output error_code,
    output receive_count, output transmit_pending, input ready
  );
  modport sink (
    input valid, input data_out, input bus_control, input read_empty,
    input frame_last, input write_accepted, input error_code,
    input receive_count, input transmit_pending, output ready
  );
endinterface

// ===== rtl/isfc_front.sv =====
// Front end: accepts requests, decodes the event code and queues the commands.
module isfc_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  isfc_req_if.sink      req_i,
  output isfc_pkg::cmd_t cmd_o,
  output logic          cmd_valid_o,
  input  logic          cmd_pop_i
);
  import isfc_pkg::*;

  cmd_t       queue_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] count_q;
  logic [1:0] count_d;
  logic       push;
  logic       pop;
  cmd_t       cmd_new;

  always_comb begin
    cmd_new.data = req_i.data_in;
    unique case (req_i.func) inside
      FUNC_HOST_READ:          cmd_new.op = OP_HOST_READ;
      FUNC_HOST_WRITE:         cmd_new.op = OP_HOST_WRITE;
      FUNC_ADDR_WRITE:         cmd_new.op = OP_ADDR_WRITE;
      FUNC_RX_ACK:             cmd_new.op = OP_RX_ACK;
      FUNC_RX_NACK:            cmd_new.op = OP_RX_NACK;
      FUNC_STOP, FUNC_TX_NACK: cmd_new.op = OP_RELEASE;
      FUNC_TX_REQ:             cmd_new.op = OP_TX_REQ;
      FUNC_FAULT:              cmd_new.op = OP_FAULT;
      default:                 cmd_new.op = OP_IGNORE;
    endcase
  end

  assign req_i.ready = (count_q != 2'd2);
  assign push        = req_i.valid && req_i.ready;
  assign cmd_valid_o = (count_q != 2'd0);
  assign pop         = cmd_valid_o && cmd_pop_i;
  assign cmd_o       = queue_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      count_q <= count_d;
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= cmd_new;
    end
  end

endmodule

// ===== rtl/isfc_back.sv =====
// Back end: ring buffers, bus state and the registered result stage.
module isfc_back #(
  parameter int RING_DEPTH = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  isfc_pkg::cmd_t cmd_i,
  input  logic           cmd_valid_i,
  output logic           cmd_pop_o,
  isfc_res_if.source     res_o
);
  import isfc_pkg::*;

  localparam int PW = (RING_DEPTH > 2) ? $clog2(RING_DEPTH) : 1;

  function automatic logic [PW-1:0] nxt(input logic [PW-1:0] p);
    return (p == PW'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [PW-1:0] occupancy(input logic [PW-1:0] head,
                                              input logic [PW-1:0] tail);
    logic [PW:0] sum;
    sum = {1'b0, head} + (PW + 1)'(RING_DEPTH) - {1'b0, tail};
    return (head >= tail) ? head - tail : sum[PW-1:0];
  endfunction

  function automatic logic [3:0] sat15(input logic [PW-1:0] c);
    logic [PW+3:0] ext;
    ext = {4'b0000, c};
    return (ext > (PW + 4)'(15)) ? COUNT_MAX : ext[3:0];
  endfunction

  logic [7:0]    rx_mem [RING_DEPTH];
  logic [7:0]    tx_mem [RING_DEPTH];
  logic [7:0]    rx_rd_q;
  logic [7:0]    tx_rd_q;

  logic [PW-1:0] rx_head_q, rx_head_d, rx_tail_q, rx_tail_d;
  logic [PW-1:0] tx_head_q, tx_head_d, tx_tail_q, tx_tail_d;
  logic [7:0]    held_byte_q, held_byte_d;
  logic          held_valid_q, held_valid_d;
  logic          busy_q, busy_d;
  err_e          err_q, err_d;

  logic          rx_we, tx_we;
  logic [7:0]    rx_wdata;
  logic          pop;
  logic          rx_full;

  ctl_e          ctl;
  logic          empty, last, acc, sel_rx, sel_tx;

  logic          res_valid_q;
  logic          sel_rx_q, sel_tx_q;
  ctl_e          ctl_q;
  logic          empty_q, last_q, acc_q;
  err_e          status_q;
  logic [3:0]    rx_count_q, tx_count_q;

  assign pop       = cmd_valid_i && (!res_valid_q || res_o.ready);
  assign cmd_pop_o = pop;
  assign rx_full   = (nxt(rx_head_q) == rx_tail_q);

  always_comb begin
    rx_head_d    = rx_head_q;
    rx_tail_d    = rx_tail_q;
    tx_head_d    = tx_head_q;
    tx_tail_d    = tx_tail_q;
    held_byte_d  = held_byte_q;
    held_valid_d = held_valid_q;
    busy_d       = busy_q;
    err_d        = err_q;
    rx_we        = 1'b0;
    tx_we        = 1'b0;
    rx_wdata     = cmd_i.data;
    ctl          = CTL_NONE;
    empty        = 1'b0;
    last         = 1'b0;
    acc          = 1'b0;
    sel_rx       = 1'b0;
    sel_tx       = 1'b0;
    if (pop) begin
      unique case (cmd_i.op)
        OP_HOST_READ: begin
          if (rx_head_q == rx_tail_q) begin
            empty = 1'b1;
          end else begin
            sel_rx    = 1'b1;
            rx_tail_d = nxt(rx_tail_q);
            if (held_valid_q) begin
              rx_we        = 1'b1;
              rx_wdata     = held_byte_q;
              rx_head_d    = nxt(rx_head_q);
              held_valid_d = 1'b0;
            end
            if (!busy_q) begin
              if (rx_head_d == rx_tail_d) begin
                last  = 1'b1;
                err_d = ERR_NONE;
                ctl   = CTL_ACK;
              end
            end else if (nxt(rx_head_d) != rx_tail_d) begin
              ctl = CTL_ACK;
            end
          end
        end
        OP_HOST_WRITE: begin
          if (nxt(tx_head_q) != tx_tail_q) begin
            tx_we     = 1'b1;
            tx_head_d = nxt(tx_head_q);
            acc       = 1'b1;
          end
        end
        OP_ADDR_WRITE: begin
          ctl    = rx_full ? CTL_NACK : CTL_ACK;
          busy_d = 1'b1;
        end
        OP_RX_ACK: begin
          held_valid_d = 1'b0;
          if (rx_full) begin
            err_d = ERR_FULL;
            ctl   = CTL_NACK;
          end else begin
            rx_we     = 1'b1;
            rx_head_d = nxt(rx_head_q);
            if (nxt(rx_head_d) == rx_tail_q) begin
              err_d = ERR_FULL;
              ctl   = CTL_NACK;
            end else begin
              err_d = ERR_NONE;
              ctl   = CTL_ACK;
            end
          end
        end
        OP_RX_NACK: begin
          held_byte_d  = cmd_i.data;
          held_valid_d = 1'b1;
          ctl          = CTL_OFF;
        end
        OP_RELEASE: begin
          busy_d = 1'b0;
          ctl    = CTL_OFF;
        end
        OP_TX_REQ: begin
          if (tx_head_q != tx_tail_q) begin
            sel_tx    = 1'b1;
            tx_tail_d = nxt(tx_tail_q);
          end
          ctl = CTL_ACK;
        end
        OP_FAULT: begin
          err_d  = ERR_FAULT;
          busy_d = 1'b0;
          ctl    = CTL_OFF;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_head_q    <= '0;
      rx_tail_q    <= '0;
      tx_head_q    <= '0;
      tx_tail_q    <= '0;
      held_valid_q <= 1'b0;
      busy_q       <= 1'b0;
      err_q        <= ERR_NONE;
      res_valid_q  <= 1'b0;
    end else begin
      rx_head_q    <= rx_head_d;
      rx_tail_q    <= rx_tail_d;
      tx_head_q    <= tx_head_d;
      tx_tail_q    <= tx_tail_d;
      held_valid_q <= held_valid_d;
      busy_q       <= busy_d;
      err_q        <= err_d;
      if (pop) begin
        res_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    held_byte_q <= held_byte_d;
    if (pop) begin
      sel_rx_q   <= sel_rx;
      sel_tx_q   <= sel_tx;
      ctl_q      <= ctl;
      empty_q    <= empty;
      last_q     <= last;
      acc_q      <= acc;
      status_q   <= busy_d ? ERR_BUSY : err_d;
      rx_count_q <= sat15(occupancy(rx_head_d, rx_tail_d));
      tx_count_q <= sat15(occupancy(tx_head_d, tx_tail_d));
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_we) begin
      rx_mem[rx_head_q] <= rx_wdata;
    end
    if (pop) begin
      rx_rd_q <= rx_mem[rx_tail_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (tx_we) begin
      tx_mem[tx_head_q] <= cmd_i.data;
    end
    if (pop) begin
      tx_rd_q <= tx_mem[tx_tail_q];
    end
  end

  assign res_o.valid            = res_valid_q;
  assign res_o.data_out         = sel_rx_q ? rx_rd_q : (sel_tx_q ? tx_rd_q : BYTE_NONE);
  assign res_o.bus_control      = ctl_q;
  assign res_o.read_empty       = empty_q;
  assign res_o.frame_last       = last_q;
  assign res_o.write_accepted   = acc_q;
  assign res_o.error_code       = status_q;
  assign res_o.receive_count    = rx_count_q;
  assign res_o.transmit_pending = tx_count_q;

endmodule

// ===== rtl/i2c_slave_fifo_controller_top.sv =====
// Top level of the I2C slave FIFO controller: front-end queue and ring back end.
// A request is stored in the command queue, then popped into the registered result stage.
// Throughput: one request per cycle while results are taken; a stalled result holds the ring update.
// A two-entry command queue lets requests be taken while a result is stalled.
// Reset clears pointers, flags and the error state at once; ring contents stay
// undefined until written, and no clearing pass is needed.
module i2c_slave_fifo_controller_top #(
  parameter int RING_DEPTH = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  isfc_req_if.sink   req_i,
  isfc_res_if.source res_o
);
  import isfc_pkg::*;

  cmd_t cmd;
  logic cmd_valid;
  logic cmd_pop;

  isfc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .cmd_o       (cmd),
    .cmd_valid_o (cmd_valid),
    .cmd_pop_i   (cmd_pop)
  );

  isfc_back #(
    .RING_DEPTH (RING_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cmd_valid_i (cmd_valid),
    .cmd_pop_o   (cmd_pop),
    .res_o       (res_o)
  );

endmodule

// ===== rtl/isfc_checker.sv =====
// Port-level assertions for the I2C slave FIFO controller and their binding.
`include "assert_macros.svh"

module isfc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  isfc_req_if.sink   req_i,
  isfc_res_if.source res_o
);
  import isfc_pkg::*;

  logic res_stall;
  logic empty_ok;
  logic last_ok;
  logic write_ok;

  assign res_stall = res_o.valid && !res_o.ready;
  assign empty_ok  = (res_o.data_out == BYTE_NONE) && (res_o.receive_count == 4'd0);
  assign last_ok   = (res_o.receive_count == 4'd0) && (res_o.bus_control == CTL_ACK) &&
                     (res_o.error_code == ERR_NONE);
  assign write_ok  = (res_o.transmit_pending != 4'd0) && (res_o.data_out == BYTE_NONE);

  `ISFC_ASSERT_NEXT(res_held_a, clk_i, rst_ni, res_stall, res_o.valid && $stable(res_o.data_out))
  `ISFC_ASSERT_NOW(req_ready_a, clk_i, rst_ni, !res_o.valid, req_i.ready)
  `ISFC_ASSERT_NOW(empty_read_a, clk_i, rst_ni, res_o.valid && res_o.read_empty, empty_ok)
  `ISFC_ASSERT_NOW(frame_last_a, clk_i, rst_ni, res_o.valid && res_o.frame_last, last_ok)
  `ISFC_ASSERT_NOW(write_acc_a, clk_i, rst_ni, res_o.valid && res_o.write_accepted, write_ok)

endmodule

bind i2c_slave_fifo_controller_top isfc_checker u_isfc_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .req_i  (req_i),
  .res_o  (res_o)
);
